// ----- design/delta_list_timer_queue_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Delta-list timer queue assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef DELTA_LIST_TIMER_QUEUE_UNIT_DEFINES_SVH
`define DELTA_LIST_TIMER_QUEUE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DLTQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DLTQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/dltq_pkg.sv -----
// ----------------------------------------------------------------------------
// Delta-list timer queue package
// Item types, operation and status codes shared by the interfaces and block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dltq_pkg;

    localparam int RESULT_LIMIT = 16;
    localparam int N_W          = $clog2(RESULT_LIMIT + 1);

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_ELAPSE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_EXPIRED  = 2'd2
    } t_status;

    typedef struct packed {
        t_op         operation;
        logic [15:0] delay_ms;
        logic [7:0]  handle;
        logic [15:0] elapsed_ms;
    } t_cmd_item;

    typedef struct packed {
        t_status     status;
        logic [7:0]  expired_handle;
        logic        last;
    } t_res_item;

    typedef struct packed {
        logic [15:0] delta;
        logic [7:0]  token;
    } t_entry;

endpackage

// ----- design/dltq_ifs.sv -----
// ----------------------------------------------------------------------------
// Delta-list timer queue channels
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dltq_cmd_if;
    import dltq_pkg::*;

    logic      valid;
    logic      ready;
    t_cmd_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dltq_res_if;
    import dltq_pkg::*;

    logic      valid;
    logic      ready;
    t_res_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/delta_list_timer_queue_unit.sv -----
// ----------------------------------------------------------------------------
// Delta-list timer queue
// Bounded queue of timeouts kept as relative delays in a circular entry memory.
// ----------------------------------------------------------------------------
// Usage: command items arrive on i_cmd, result items leave on o_res, both
// valid/ready. An insert item gives one result, inserted or dropped when the
// queue holds MAX_TIMEOUTS entries. An elapse item takes its time off the
// head entry and gives one expired result per leading zero-delay entry, at
// most sixteen, the final one marked last; it may give no result at all.
// One sequencer drives a single subtract/compare unit and one port pair of
// the entry memory, so i_cmd is ready only while no item is in progress. An
// insert walks the list, reading each entry and comparing it, then shifts the
// later entries up one slot and writes the new one; a dropped insert goes
// straight to its result. The memory read is registered. An elapse reads and
// updates the head, then reads each next entry to see if it expires as well.
// A result sits in an output register, so the
// next command is taken while the last result still waits. When o_res
// stalls, the sequencer waits before it emits another result. Reset empties
// the queue at once; the entry memory itself is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "delta_list_timer_queue_unit_defines.svh"

module delta_list_timer_queue_unit #(
    parameter int MAX_TIMEOUTS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dltq_cmd_if.sink   i_cmd,
    dltq_res_if.source o_res
);
    import dltq_pkg::*;

    localparam int CW = $clog2(MAX_TIMEOUTS + 1);
    localparam int IW = (MAX_TIMEOUTS > 1) ? $clog2(MAX_TIMEOUTS) : 1;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_WALK_RD  = 11'b00000000010,
        S_WALK_CMP = 11'b00000000100,
        S_SHIFT_RD = 11'b00000001000,
        S_SHIFT_WR = 11'b00000010000,
        S_PLACE    = 11'b00000100000,
        S_HEAD_RD  = 11'b00001000000,
        S_HEAD_UPD = 11'b00010000000,
        S_NEXT_RD  = 11'b00100000000,
        S_NEXT_CHK = 11'b01000000000,
        S_EMIT     = 11'b10000000000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [IW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_pos, n_pos;
    logic [CW-1:0]   r_i, n_i;
    logic [15:0]     r_rem, n_rem;
    logic [7:0]      r_tok, n_tok;
    logic [N_W-1:0]  r_n, n_n;
    t_status         r_res_status, n_res_status;
    logic [7:0]      r_res_tok, n_res_tok;
    logic            r_res_last, n_res_last;
    logic            r_more, n_more;
    logic [7:0]      r_next_tok, n_next_tok;
    logic            r_ovalid, n_ovalid;
    t_res_item       r_odata, n_odata;

    t_entry          r_mem [MAX_TIMEOUTS];
    t_entry          r_rd_data;
    logic            mem_we;
    t_entry          mem_wdata;
    logic [CW-1:0]   addr_log;
    logic [CW:0]     addr_sum;
    logic [IW-1:0]   addr_phys;
    logic [15:0]     sub_a, sub_b;
    logic [16:0]     sub_diff;
    logic            sub_borrow;
    logic [15:0]     head_new;
    logic            can_emit;
    logic            cmd_take;
    logic [IW-1:0]   head_inc;
    logic [CW-1:0]   pop_count;
    logic [N_W-1:0]  pop_n;

    assign can_emit    = !r_ovalid || o_res.ready;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign cmd_take    = i_cmd.valid && i_cmd.ready;
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_odata;

    assign head_inc = (r_head == IW'(MAX_TIMEOUTS - 1)) ? '0 : r_head + 1'b1;

    // Logical list position to memory address around the circular head.
    always_comb begin
        addr_sum = (CW + 1)'(r_head) + {1'b0, addr_log};
        if (addr_sum >= (CW + 1)'(MAX_TIMEOUTS)) begin
            addr_sum = addr_sum - (CW + 1)'(MAX_TIMEOUTS);
        end
        addr_phys = addr_sum[IW-1:0];
    end

    always_comb begin
        unique case (r_state) inside
            S_WALK_RD, S_WALK_CMP, S_PLACE: addr_log = r_pos;
            S_SHIFT_RD:                     addr_log = r_i - 1'b1;
            S_SHIFT_WR:                     addr_log = r_i;
            default:                        addr_log = '0;
        endcase
    end

    // Shared subtract and compare unit.
    always_comb begin
        if (r_state == S_HEAD_UPD) begin
            sub_a = r_rd_data.delta;
            sub_b = r_rem;
        end else begin
            sub_a = r_rem;
            sub_b = r_rd_data.delta;
        end
        sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
        sub_borrow = sub_diff[16];
        head_new   = sub_borrow ? 16'd0 : sub_diff[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[addr_phys] <= mem_wdata;
        end
        r_rd_data <= r_mem[addr_phys];
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_head       = r_head;
        n_pos        = r_pos;
        n_i          = r_i;
        n_rem        = r_rem;
        n_tok        = r_tok;
        n_n          = r_n;
        n_res_status = r_res_status;
        n_res_tok    = r_res_tok;
        n_res_last   = r_res_last;
        n_more       = r_more;
        n_next_tok   = r_next_tok;
        n_ovalid     = r_ovalid;
        n_odata      = r_odata;
        mem_we       = 1'b0;
        mem_wdata    = r_rd_data;
        pop_count    = r_count - 1'b1;
        pop_n        = (r_state == S_HEAD_UPD) ? N_W'(1) : r_n + 1'b1;

        if (o_res.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (cmd_take) begin
                    n_tok = i_cmd.data.handle;
                    n_pos = '0;
                    if (i_cmd.data.operation == OP_ELAPSE) begin
                        n_rem = i_cmd.data.elapsed_ms;
                        if (r_count != '0) begin
                            n_state = S_HEAD_RD;
                        end
                    end else begin
                        n_rem = i_cmd.data.delay_ms;
                        if (r_count == CW'(MAX_TIMEOUTS)) begin
                            n_res_status = ST_DROPPED;
                            n_res_tok    = '0;
                            n_res_last   = 1'b1;
                            n_more       = 1'b0;
                            n_state      = S_EMIT;
                        end else begin
                            n_state = S_WALK_RD;
                        end
                    end
                end
            end
            S_WALK_RD: begin
                if (r_pos == r_count) begin
                    n_i     = r_count;
                    n_state = S_SHIFT_RD;
                end else begin
                    n_state = S_WALK_CMP;
                end
            end
            S_WALK_CMP: begin
                if (!sub_borrow) begin
                    n_rem   = sub_diff[15:0];
                    n_pos   = r_pos + 1'b1;
                    n_state = S_WALK_RD;
                end else begin
                    mem_we          = 1'b1;
                    mem_wdata.delta = ~sub_diff[15:0] + 16'd1;
                    n_i             = r_count;
                    n_state         = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: begin
                if (r_i == r_pos) begin
                    n_state = S_PLACE;
                end else begin
                    n_state = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                mem_we  = 1'b1;
                n_i     = r_i - 1'b1;
                n_state = S_SHIFT_RD;
            end
            S_PLACE: begin
                mem_we          = 1'b1;
                mem_wdata.delta = r_rem;
                mem_wdata.token = r_tok;
                n_count         = r_count + 1'b1;
                n_res_status    = ST_INSERTED;
                n_res_tok       = '0;
                n_res_last      = 1'b1;
                n_more          = 1'b0;
                n_state         = S_EMIT;
            end
            S_HEAD_RD: begin
                n_state = S_HEAD_UPD;
            end
            S_HEAD_UPD: begin
                mem_we          = 1'b1;
                mem_wdata.delta = head_new;
                if (head_new != 16'd0) begin
                    n_state = S_IDLE;
                end else begin
                    n_res_status = ST_EXPIRED;
                    n_res_tok    = r_rd_data.token;
                    n_head       = head_inc;
                    n_count      = pop_count;
                    n_n          = pop_n;
                    if (pop_count != '0 && pop_n != N_W'(RESULT_LIMIT)) begin
                        n_state = S_NEXT_RD;
                    end else begin
                        n_res_last = 1'b1;
                        n_more     = 1'b0;
                        n_state    = S_EMIT;
                    end
                end
            end
            S_NEXT_RD: begin
                n_state = S_NEXT_CHK;
            end
            S_NEXT_CHK: begin
                n_more     = (r_rd_data.delta == 16'd0);
                n_res_last = (r_rd_data.delta != 16'd0);
                n_next_tok = r_rd_data.token;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (can_emit) begin
                    n_ovalid                = 1'b1;
                    n_odata.status          = r_res_status;
                    n_odata.expired_handle  = r_res_tok;
                    n_odata.last            = r_res_last;
                    if (r_more) begin
                        n_res_tok = r_next_tok;
                        n_head    = head_inc;
                        n_count   = pop_count;
                        n_n       = pop_n;
                        if (pop_count != '0 && pop_n != N_W'(RESULT_LIMIT)) begin
                            n_state = S_NEXT_RD;
                        end else begin
                            n_res_last = 1'b1;
                            n_more     = 1'b0;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_head   <= '0;
            r_ovalid <= 1'b0;
            r_more   <= 1'b0;
            r_n      <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_head   <= n_head;
            r_ovalid <= n_ovalid;
            r_more   <= n_more;
            r_n      <= n_n;
        end
        r_pos        <= n_pos;
        r_i          <= n_i;
        r_rem        <= n_rem;
        r_tok        <= n_tok;
        r_res_status <= n_res_status;
        r_res_tok    <= n_res_tok;
        r_res_last   <= n_res_last;
        r_next_tok   <= n_next_tok;
        r_odata      <= n_odata;
    end

    `DLTQ_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(MAX_TIMEOUTS), "Entry count overflow.")
    `DLTQ_ASSERT_NEXT(a_place_grows, r_state == S_PLACE, r_count == $past(r_count) + 1'b1, "Insert did not add one entry.")
    `DLTQ_ASSERT_NOW(a_single_last, o_res.valid && o_res.data.status != ST_EXPIRED, o_res.data.last && o_res.data.expired_handle == 8'd0, "Insert result not marked last.")
    `DLTQ_ASSERT_NOW(a_pop_bound, 1'b1, r_n <= N_W'(RESULT_LIMIT), "Too many entries popped.")

endmodule

// ----- test/delta_list_timer_queue_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Delta-list timer queue testbench
// Sends insert and elapse items and predicts every inserted, dropped and
// expired result from a private copy of the list. Each result is compared
// field by field with the oldest prediction. Both sides idle in random bursts,
// and the result side also holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module delta_list_timer_queue_unit_tb;
    import dltq_pkg::*;

    localparam int TIMER_SLOTS = 16;
    localparam int ITEM_TARGET = 450;
    localparam int CALM_TAIL   = 60;
    localparam int LONG_HOLD   = 400;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 100;

    class timer_list_checker;
        logic [15:0] delta_list [TIMER_SLOTS];
        logic [7:0]  token_list [TIMER_SLOTS];
        int unsigned live_count;
        t_res_item   due_results [$];
        int unsigned errors;

        function new();
            live_count = 0;
            errors     = 0;
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction

        function void note_command(t_cmd_item c);
            int unsigned pos;
            int unsigned fired;
            logic [15:0] rem;
            if (c.operation == OP_INSERT) begin
                if (live_count >= TIMER_SLOTS) begin
                    due_results.push_back(t_res_item'{ST_DROPPED, 8'h00, 1'b1});
                    return;
                end
                pos = 0;
                rem = c.delay_ms;
                while (pos < live_count && delta_list[pos] <= rem) begin
                    rem = rem - delta_list[pos];
                    pos++;
                end
                if (pos < live_count)
                    delta_list[pos] = delta_list[pos] - rem;
                for (int i = live_count; i > pos; i--) begin
                    delta_list[i] = delta_list[i - 1];
                    token_list[i] = token_list[i - 1];
                end
                delta_list[pos] = rem;
                token_list[pos] = c.handle;
                live_count++;
                due_results.push_back(t_res_item'{ST_INSERTED, 8'h00, 1'b1});
            end else begin
                if (live_count == 0)
                    return;
                if (c.elapsed_ms <= delta_list[0])
                    delta_list[0] = delta_list[0] - c.elapsed_ms;
                else
                    delta_list[0] = 16'd0;
                fired = 0;
                while (live_count > 0 && delta_list[0] == 16'd0 && fired < RESULT_LIMIT) begin
                    due_results.push_back(t_res_item'{ST_EXPIRED, token_list[0], 1'b0});
                    for (int i = 1; i < live_count; i++) begin
                        delta_list[i - 1] = delta_list[i];
                        token_list[i - 1] = token_list[i];
                    end
                    live_count--;
                    fired++;
                end
                if (fired > 0)
                    due_results[due_results.size() - 1].last = 1'b1;
            end
        endfunction

        function void check_result(t_res_item got);
            t_res_item want;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d handle %0h last %0b",
                         $time, got.status, got.expired_handle, got.last);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.expired_handle !== want.expired_handle) begin
                $display("%0t: expired_handle mismatch, expected %0h, actual %0h",
                         $time, want.expired_handle, got.expired_handle);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last mismatch, expected %0b, actual %0b",
                         $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    dltq_cmd_if cmd_ch ();
    dltq_res_if res_ch ();

    delta_list_timer_queue_unit #(
        .MAX_TIMEOUTS(TIMER_SLOTS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch),
        .o_res  (res_ch)
    );

    timer_list_checker book = new();
    int unsigned       items_sent = 0;
    bit                tx_idling  = 1'b0;
    bit                rx_idling  = 1'b0;
    bit                hold_asked = 1'b0;
    int unsigned       quiet_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [15:0] pick_delay();
        logic [15:0] v;
        case ($urandom_range(0, 9)) inside
            0, 1, 2, 3: v = 16'($urandom_range(0, 15));
            4, 5:       v = 16'($urandom_range(0, 200));
            6:          v = 16'hFFFF;
            7:          v = 16'h0000;
            default:    v = 16'($urandom());
        endcase
        return v;
    endfunction

    function automatic logic [15:0] pick_elapsed();
        logic [15:0] v;
        case ($urandom_range(0, 9)) inside
            0, 1, 2: v = 16'h0000;
            3, 4, 5: v = 16'($urandom_range(1, 20));
            6, 7:    v = 16'hFFFF;
            default: v = 16'($urandom());
        endcase
        return v;
    endfunction

    function automatic t_cmd_item insert_item(logic [15:0] d, logic [7:0] h);
        t_cmd_item c;
        c.operation  = OP_INSERT;
        c.delay_ms   = d;
        c.handle     = h;
        c.elapsed_ms = 16'($urandom());
        return c;
    endfunction

    function automatic t_cmd_item elapse_item(logic [15:0] e);
        t_cmd_item c;
        c.operation  = OP_ELAPSE;
        c.delay_ms   = 16'($urandom());
        c.handle     = 8'($urandom());
        c.elapsed_ms = e;
        return c;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_cmd(input t_cmd_item c);
        if (tx_idling && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        cmd_ch.data  = c;
        cmd_ch.valid = 1'b1;
        @(posedge i_clk);
        while (!cmd_ch.ready)
            @(posedge i_clk);
        book.note_command(c);
        items_sent++;
        @(negedge i_clk);
        cmd_ch.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (book.pending() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        int unsigned stall_left;
        stall_left   = 0;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_asked) begin
                hold_asked   = 1'b0;
                res_ch.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end
            if (stall_left > 0) begin
                res_ch.ready = 1'b0;
                stall_left--;
            end else if (rx_idling && $urandom_range(0, 5) == 0) begin
                res_ch.ready = 1'b0;
                stall_left   = $urandom_range(1, 16) - 1;
            end else begin
                res_ch.ready = 1'b1;
            end
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready)
                book.check_result(res_ch.data);
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int unsigned burst;
        int unsigned kind;
        logic [15:0] shared_delay;
        bit          held;
        held         = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        i_rst_n      = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty elapse, equal total times, clamping, full store.
        send_cmd(elapse_item(16'hFFFF));
        send_cmd(insert_item(16'h0000, 8'h00));
        send_cmd(insert_item(16'hFFFF, 8'hFF));
        send_cmd(insert_item(16'd100, 8'h55));
        send_cmd(insert_item(16'd100, 8'hAA));
        send_cmd(insert_item(16'd50, 8'h01));
        send_cmd(insert_item(16'h0000, 8'h02));
        send_cmd(elapse_item(16'h0000));
        send_cmd(elapse_item(16'd30));
        send_cmd(elapse_item(16'hFFFF));
        for (int i = 0; i < 13; i++)
            send_cmd(insert_item(16'h0000, 8'(i * 19 + 3)));
        send_cmd(insert_item(16'd1234, 8'h3C));
        send_cmd(elapse_item(16'h0000));
        wait_drained();

        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= ITEM_TARGET - CALM_TAIL) begin
                tx_idling = 1'b0;
                rx_idling = 1'b0;
            end else begin
                tx_idling = ($urandom_range(0, 3) != 0);
                rx_idling = ($urandom_range(0, 3) != 0);
            end
            if (!held && items_sent >= 200) begin
                // The result side stalls while inserts keep coming.
                held       = 1'b1;
                hold_asked = 1'b1;
                for (int i = 0; i < 20; i++)
                    send_cmd(insert_item(pick_delay(), 8'($urandom())));
                wait_drained();
            end
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                burst = $urandom_range(1, 18);
                for (int i = 0; i < burst; i++) begin
                    if ($urandom_range(0, 2) == 0)
                        send_cmd(insert_item(16'($urandom_range(0, 2) * 5), 8'($urandom())));
                    else
                        send_cmd(insert_item(pick_delay(), 8'($urandom())));
                end
                burst = $urandom_range(1, 5);
                for (int i = 0; i < burst; i++)
                    send_cmd(elapse_item(pick_elapsed()));
            end else if (kind <= 7) begin
                shared_delay = 16'($urandom_range(0, 3) * 4);
                burst        = $urandom_range(8, 17);
                for (int i = 0; i < burst; i++)
                    send_cmd(insert_item(shared_delay, 8'($urandom())));
                send_cmd(elapse_item($urandom_range(0, 1) ? 16'hFFFF : shared_delay));
                send_cmd(elapse_item(pick_elapsed()));
            end else begin
                for (int i = 0; i < 6; i++) begin
                    if ($urandom_range(0, 1))
                        send_cmd(insert_item(16'($urandom()), 8'($urandom())));
                    else
                        send_cmd(elapse_item(16'($urandom())));
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (book.errors == 0 && book.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
